FILE: hdl/aic_pkg.sv
// ----------------------------------------------------------------------------
// aic_pkg
// Shared types, status codes and helpers for the box intersection classifier.
// ----------------------------------------------------------------------------
package aic_pkg;

    localparam int COORD_W = 32;
    localparam int WIDE_W  = COORD_W + 1;
    localparam int TOL_W   = 16;
    localparam int AXES    = 3;
    localparam int BOX_W   = 2 * AXES * COORD_W;
    localparam int STAT_W  = 3;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [WIDE_W-1:0]  wcoord_t;

    // lower half holds the mins, x in the lowest bits
    typedef struct packed {
        coord_t [AXES-1:0] hi;
        coord_t [AXES-1:0] lo;
    } box_t;

    typedef enum logic [STAT_W-1:0] {
        ST_UNKNOWN = 3'd0,
        ST_NOT     = 3'd1,
        ST_B_IN_A  = 3'd2,
        ST_A_IN_B  = 3'd3,
        ST_OK      = 3'd4
    } status_t;

    // stage 1 -> stage 2: boxes and tolerance-widened bounds
    typedef struct packed {
        box_t               a;
        box_t               b;
        wcoord_t [AXES-1:0] a_lo_w;
        wcoord_t [AXES-1:0] a_hi_w;
        wcoord_t [AXES-1:0] b_lo_w;
        wcoord_t [AXES-1:0] b_hi_w;
        logic               boxes_ok;
    } s1_t;

    // stage 2 -> stage 3: per-pair case flags and candidate results
    typedef struct packed {
        box_t a;
        box_t b;
        box_t isect;
        logic boxes_ok;
        logic disjoint;
        logic b_in_a;
        logic a_in_b;
    } s2_t;

    // sign-extend a coordinate by one bit
    function automatic wcoord_t sx_w(input coord_t c);
        return {c[COORD_W-1], c};
    endfunction

    // signed less-than on widened values
    function automatic logic lt_w(input wcoord_t x, input wcoord_t y);
        return $signed(x) < $signed(y);
    endfunction

endpackage

FILE: hdl/aic_widen.sv
// ----------------------------------------------------------------------------
// aic_widen
// Stage 1: box validity check and tolerance-widened bounds, one bit wider.
// ----------------------------------------------------------------------------
module aic_widen (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          in_valid,
    input  aic_pkg::box_t                 in_a,
    input  aic_pkg::box_t                 in_b,
    input  logic [aic_pkg::TOL_W-1:0]     tolerance,
    output logic                          out_valid,
    output aic_pkg::s1_t                  out_data
);
    import aic_pkg::*;

    logic    valid_reg;
    s1_t     data_reg;
    s1_t     data_next;
    wcoord_t tol_w;

    assign tol_w = WIDE_W'(tolerance);

    // widened bounds and validity per axis
    always_comb begin
        data_next          = '0;
        data_next.a        = in_a;
        data_next.b        = in_b;
        data_next.boxes_ok = 1'b1;
        for (int k = 0; k < AXES; k++) begin
            data_next.a_lo_w[k] = sx_w(in_a.lo[k]) - tol_w;
            data_next.a_hi_w[k] = sx_w(in_a.hi[k]) + tol_w;
            data_next.b_lo_w[k] = sx_w(in_b.lo[k]) - tol_w;
            data_next.b_hi_w[k] = sx_w(in_b.hi[k]) + tol_w;
            if (lt_w(sx_w(in_a.hi[k]), sx_w(in_a.lo[k])) ||
                lt_w(sx_w(in_b.hi[k]), sx_w(in_b.lo[k]))) begin
                data_next.boxes_ok = 1'b0;
            end
        end
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hdl/aic_compare.sv
// ----------------------------------------------------------------------------
// aic_compare
// Stage 2: disjoint and containment tests per axis, overlap box candidates.
// ----------------------------------------------------------------------------
module aic_compare (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          in_valid,
    input  aic_pkg::s1_t  in_data,
    output logic          out_valid,
    output aic_pkg::s2_t  out_data
);
    import aic_pkg::*;

    logic valid_reg;
    s2_t  data_reg;
    s2_t  data_next;

    // per-axis flags reduced over the three axes
    always_comb begin
        wcoord_t alo;
        wcoord_t ahi;
        wcoord_t blo;
        wcoord_t bhi;
        data_next          = '0;
        data_next.a        = in_data.a;
        data_next.b        = in_data.b;
        data_next.boxes_ok = in_data.boxes_ok;
        data_next.b_in_a   = 1'b1;
        data_next.a_in_b   = 1'b1;
        for (int k = 0; k < AXES; k++) begin
            alo = sx_w(in_data.a.lo[k]);
            ahi = sx_w(in_data.a.hi[k]);
            blo = sx_w(in_data.b.lo[k]);
            bhi = sx_w(in_data.b.hi[k]);
            if (lt_w(in_data.a_hi_w[k], blo) || lt_w(in_data.b_hi_w[k], alo)) begin
                data_next.disjoint = 1'b1;
            end
            // b corners outside widened a
            if (lt_w(blo, in_data.a_lo_w[k]) || lt_w(in_data.a_hi_w[k], blo) ||
                lt_w(bhi, in_data.a_lo_w[k]) || lt_w(in_data.a_hi_w[k], bhi)) begin
                data_next.b_in_a = 1'b0;
            end
            // a corners outside widened b
            if (lt_w(alo, in_data.b_lo_w[k]) || lt_w(in_data.b_hi_w[k], alo) ||
                lt_w(ahi, in_data.b_lo_w[k]) || lt_w(in_data.b_hi_w[k], ahi)) begin
                data_next.a_in_b = 1'b0;
            end
            data_next.isect.lo[k] = lt_w(blo, alo) ? in_data.a.lo[k] : in_data.b.lo[k];
            data_next.isect.hi[k] = lt_w(ahi, bhi) ? in_data.a.hi[k] : in_data.b.hi[k];
        end
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hdl/aic_select.sv
// ----------------------------------------------------------------------------
// aic_select
// Stage 3: status priority and result box selection into the output register.
// ----------------------------------------------------------------------------
module aic_select (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  aic_pkg::s2_t      in_data,
    output logic              out_valid,
    output aic_pkg::status_t  out_status,
    output aic_pkg::box_t     out_box
);
    import aic_pkg::*;

    logic    valid_reg;
    status_t status_reg;
    status_t status_next;
    box_t    box_reg;
    box_t    box_next;

    // first case that holds wins
    always_comb begin
        priority if (!in_data.boxes_ok) begin
            status_next = ST_UNKNOWN;
            box_next    = '0;
        end else if (in_data.disjoint) begin
            status_next = ST_NOT;
            box_next    = '0;
        end else if (in_data.b_in_a) begin
            status_next = ST_B_IN_A;
            box_next    = in_data.b;
        end else if (in_data.a_in_b) begin
            status_next = ST_A_IN_B;
            box_next    = in_data.a;
        end else begin
            status_next = ST_OK;
            box_next    = in_data.isect;
        end
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            status_reg <= status_next;
            box_reg    <= box_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_box    = box_reg;

endmodule

FILE: hdl/aabb_intersect_classify.sv
// ----------------------------------------------------------------------------
// aabb_intersect_classify
// Classifies the intersection of two 3D axis-aligned boxes in signed Q16.16.
// ----------------------------------------------------------------------------
// Takes one box pair per cycle while the output side is not stalled and
// returns one result per pair. Each pair passes through the three register
// stages: widening of the bounds by the tolerance, the per-axis disjoint and
// containment compares, and the status priority with result selection into
// the output register. Stages advance
// independently, so bubbles close up while the output waits and a request is
// still taken. Status is unknown for an invalid box, then not intersecting,
// B inside A, A inside B and partial overlap; for the first two the result box
// is zero. The tolerance register resets to 1 and should only be written while
// no requests are in flight.
module aabb_intersect_classify (
    input  logic                          aclk,
    input  logic                          aresetn,
    // tolerance register write
    input  logic                          cfg_wr_en,
    input  logic [aic_pkg::TOL_W-1:0]     cfg_wr_data,
    // box pair requests
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // a_min_x, a_min_y, a_min_z, a_max_x, a_max_y, a_max_z,
    // b_min_x, b_min_y, b_min_z, b_max_x, b_max_y, b_max_z
    input  logic [2*aic_pkg::BOX_W-1:0]   s_tdata,
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // res_min_x, res_min_y, res_min_z, res_max_x, res_max_y, res_max_z
    output logic [aic_pkg::BOX_W-1:0]     m_tdata,
    // status
    output logic [aic_pkg::STAT_W-1:0]    m_tuser
);
    import aic_pkg::*;

    logic [TOL_W-1:0] tol_reg;
    logic             v1;
    logic             v2;
    logic             v3;
    logic             adv1;
    logic             adv2;
    logic             adv3;
    s1_t              s1_data;
    s2_t              s2_data;
    status_t          res_status;
    box_t             res_box;

    // tolerance register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (cfg_wr_en) begin
            tol_reg <= cfg_wr_data;
        end
    end

    // a stage loads when it is empty or its contents move on
    assign adv3     = !v3 || m_tready;
    assign adv2     = !v2 || adv3;
    assign adv1     = !v1 || adv2;
    assign s_tready = adv1;

    aic_widen u_widen (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv1),
        .in_valid  (s_tvalid),
        .in_a      (box_t'(s_tdata[BOX_W-1:0])),
        .in_b      (box_t'(s_tdata[2*BOX_W-1:BOX_W])),
        .tolerance (tol_reg),
        .out_valid (v1),
        .out_data  (s1_data)
    );

    aic_compare u_compare (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv2),
        .in_valid  (v1),
        .in_data   (s1_data),
        .out_valid (v2),
        .out_data  (s2_data)
    );

    aic_select u_select (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv3),
        .in_valid   (v2),
        .in_data    (s2_data),
        .out_valid  (v3),
        .out_status (res_status),
        .out_box    (res_box)
    );

    assign m_tvalid = v3;
    assign m_tdata  = res_box;
    assign m_tuser  = res_status;

endmodule

FILE: hdl/aic_checker.sv
// ----------------------------------------------------------------------------
// aic_checker
// Port-level checks on the box intersection classifier, bound to the top.
// ----------------------------------------------------------------------------
module aic_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [aic_pkg::BOX_W-1:0]     m_tdata,
    input  logic [aic_pkg::STAT_W-1:0]    m_tuser
);
    import aic_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // an empty output stage never back-pressures the input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("request refused with empty output");

    // unknown and not intersecting give a zero box
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_UNKNOWN || m_tuser == ST_NOT) |-> m_tdata == '0)
        else $error("non-zero box for unknown or disjoint");

    // a contained box is a valid box
    a_contained: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_B_IN_A || m_tuser == ST_A_IN_B) |->
            $signed(m_tdata[127:96]) >= $signed(m_tdata[31:0]) &&
            $signed(m_tdata[159:128]) >= $signed(m_tdata[63:32]) &&
            $signed(m_tdata[191:160]) >= $signed(m_tdata[95:64]))
        else $error("contained box has max below min");

endmodule

bind aabb_intersect_classify aic_checker u_aic_checker (.*);

FILE: test/aabb_intersect_classify_tb.sv
// ----------------------------------------------------------------------------
// aabb_intersect_classify_tb
// Self-checking bench for the 3D box intersection classifier.
// ----------------------------------------------------------------------------
// Box pairs go in on the slave stream and results come back on the master
// stream. Each accepted request is predicted from the table or by a classifier
// in the bench and the prediction is queued; every result is checked field by
// field against the oldest prediction. A short table of directed pairs covers
// invalid, disjoint, containment and overlap cases and coordinate extremes, then
// random pairs follow, mostly built close to each other so that every case
// and the tolerance edges are reached. The tolerance is changed between
// phases while the block is empty, and both streams stall at random, with
// one long hold-off on the result side that backs the pipeline up.
// ----------------------------------------------------------------------------
module aabb_intersect_classify_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aic_pkg::*;

    localparam int  HALF_PERIOD  = 5;
    localparam int  RESET_CYCLES = 5;
    localparam int  SETTLE       = 12;
    localparam int  HOLD_LEN     = 400;
    localparam int  STALL_LIMIT  = 4000;
    localparam int  N_PHASES     = 5;
    localparam int  ONE          = 65536;
    localparam int  C_MAX        = 32'sh7fff_ffff;
    localparam int  C_MIN        = 32'sh8000_0000;

    typedef struct packed {
        status_t status;
        box_t    box;
    } isect_t;

    typedef struct {
        box_t   a;
        box_t   b;
        logic   given;
        isect_t want;
    } pair_row_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [TOL_W-1:0]       cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [2*BOX_W-1:0]     s_tdata     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [BOX_W-1:0]       m_tdata;
    logic [STAT_W-1:0]      m_tuser;

    isect_t                 isect_due[$];
    logic [TOL_W-1:0]       tol_now      = TOL_RESET;
    int                     err_count    = 0;
    int                     src_idle_pct = 38;
    int                     snk_idle_pct = 78;
    int                     hold_seq     = 0;
    int                     hold_seen    = 0;
    int                     hold_left    = 0;
    int                     quiet        = 0;

    aabb_intersect_classify u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // clock
    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // box from min and max corners
    function automatic box_t mk_box(int lx, int ly, int lz, int hx, int hy, int hz);
        box_t r;
        r.lo[0] = coord_t'(lx);
        r.lo[1] = coord_t'(ly);
        r.lo[2] = coord_t'(lz);
        r.hi[0] = coord_t'(hx);
        r.hi[1] = coord_t'(hy);
        r.hi[2] = coord_t'(hz);
        return r;
    endfunction

    function automatic pair_row_t row(box_t a, box_t b, logic given, status_t st, box_t res);
        pair_row_t r;
        r.a           = a;
        r.b           = b;
        r.given       = given;
        r.want.status = st;
        r.want.box    = res;
        return r;
    endfunction

    // classify a pair of boxes, all tolerance sums done in 64 bits
    function automatic isect_t classify_boxes(box_t a, box_t b, logic [TOL_W-1:0] tol);
        longint t;
        longint alo [AXES];
        longint ahi [AXES];
        longint blo [AXES];
        longint bhi [AXES];
        logic   a_ok, b_ok, apart, b_in_a, a_in_b;
        isect_t r;
        t      = longint'(tol);
        a_ok   = 1'b1;
        b_ok   = 1'b1;
        apart  = 1'b0;
        b_in_a = 1'b1;
        a_in_b = 1'b1;
        for (int k = 0; k < AXES; k++) begin
            alo[k] = longint'($signed(a.lo[k]));
            ahi[k] = longint'($signed(a.hi[k]));
            blo[k] = longint'($signed(b.lo[k]));
            bhi[k] = longint'($signed(b.hi[k]));
            if (ahi[k] < alo[k]) a_ok = 1'b0;
            if (bhi[k] < blo[k]) b_ok = 1'b0;
            if (ahi[k] + t < blo[k] || bhi[k] + t < alo[k]) apart = 1'b1;
            if (blo[k] < alo[k] - t || blo[k] > ahi[k] + t ||
                bhi[k] < alo[k] - t || bhi[k] > ahi[k] + t) b_in_a = 1'b0;
            if (alo[k] < blo[k] - t || alo[k] > bhi[k] + t ||
                ahi[k] < blo[k] - t || ahi[k] > bhi[k] + t) a_in_b = 1'b0;
        end
        r.box = '0;
        if (!(a_ok && b_ok)) begin
            r.status = ST_UNKNOWN;
        end else if (apart) begin
            r.status = ST_NOT;
        end else if (b_in_a) begin
            r.status = ST_B_IN_A;
            r.box    = b;
        end else if (a_in_b) begin
            r.status = ST_A_IN_B;
            r.box    = a;
        end else begin
            r.status = ST_OK;
            for (int k = 0; k < AXES; k++) begin
                r.box.lo[k] = (alo[k] > blo[k]) ? a.lo[k] : b.lo[k];
                r.box.hi[k] = (ahi[k] < bhi[k]) ? a.hi[k] : b.hi[k];
            end
        end
        return r;
    endfunction

    // saturate to the coordinate range
    function automatic coord_t clamp_c(longint v);
        if (v > longint'(C_MAX)) return coord_t'(C_MAX);
        if (v < longint'(C_MIN)) return coord_t'(C_MIN);
        return coord_t'(v);
    endfunction

    // uniform offset in [-r, r]
    function automatic longint rand_off(longint r);
        return longint'($urandom_range(0, 2 * r)) - r;
    endfunction

    // random pair: some noise, some wide valid boxes, mostly close neighbours
    function automatic void make_pair(output box_t a, output box_t b);
        int     pick, shape, k;
        longint reach, base, lo, hi, blo, bhi, t;
        coord_t tmp;
        t    = longint'(tol_now);
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            for (k = 0; k < AXES; k++) begin
                a.lo[k] = $urandom;
                a.hi[k] = $urandom;
                b.lo[k] = $urandom;
                b.hi[k] = $urandom;
            end
            return;
        end
        if (pick < 18) begin
            for (k = 0; k < AXES; k++) begin
                a.lo[k] = $urandom;
                a.hi[k] = $urandom;
                b.lo[k] = $urandom;
                b.hi[k] = $urandom;
                if ($signed(a.hi[k]) < $signed(a.lo[k])) begin
                    tmp = a.lo[k]; a.lo[k] = a.hi[k]; a.hi[k] = tmp;
                end
                if ($signed(b.hi[k]) < $signed(b.lo[k])) begin
                    tmp = b.lo[k]; b.lo[k] = b.hi[k]; b.hi[k] = tmp;
                end
            end
            return;
        end
        case ($urandom_range(0, 3))
            0:       reach = 4;
            1:       reach = t + 2;
            2:       reach = ONE;
            default: reach = 1 << 20;
        endcase
        shape = $urandom_range(0, 4);
        for (k = 0; k < AXES; k++) begin
            case ($urandom_range(0, 7))
                0:       base = longint'(C_MIN);
                1:       base = longint'(C_MAX);
                default: base = longint'($signed($urandom));
            endcase
            a.lo[k] = clamp_c(base + rand_off(reach));
            a.hi[k] = clamp_c(longint'($signed(a.lo[k])) + $urandom_range(0, reach));
            lo = longint'($signed(a.lo[k]));
            hi = longint'($signed(a.hi[k]));
            case (shape)
                // unrelated box in the same neighbourhood
                0: begin
                    blo = base + rand_off(reach);
                    bhi = blo + $urandom_range(0, reach);
                end
                // near copy of a, edges moved by about the tolerance
                1: begin
                    blo = lo + rand_off(t + 2);
                    bhi = hi + rand_off(t + 2);
                end
                // b within a
                2: begin
                    blo = lo + $urandom_range(0, hi - lo);
                    bhi = blo + $urandom_range(0, hi - blo);
                end
                // b around a
                3: begin
                    blo = lo - $urandom_range(0, reach);
                    bhi = hi + $urandom_range(0, reach);
                end
                // edge touching at the tolerance limit on some axes
                default: begin
                    if ($urandom_range(0, 2) != 0) begin
                        blo = lo + rand_off(t + 2);
                        bhi = hi + rand_off(t + 2);
                    end else if ($urandom_range(0, 1) != 0) begin
                        blo = hi + t + $urandom_range(0, 1);
                        bhi = blo + $urandom_range(0, reach);
                    end else begin
                        bhi = lo - t - $urandom_range(0, 1);
                        blo = bhi - $urandom_range(0, reach);
                    end
                end
            endcase
            b.lo[k] = clamp_c(blo);
            b.hi[k] = clamp_c(bhi);
        end
        // now and then flip one axis to make a box invalid
        if ($urandom_range(0, 19) == 0) begin
            k = $urandom_range(0, AXES - 1);
            if ($urandom_range(0, 1) != 0) begin
                tmp = a.lo[k]; a.lo[k] = a.hi[k]; a.hi[k] = tmp;
            end else begin
                tmp = b.lo[k]; b.lo[k] = b.hi[k]; b.hi[k] = tmp;
            end
        end
    endfunction

    task automatic flag_mismatch(string field, longint got, longint want);
        err_count++;
        $display("%0t mismatch %s: got %0h expected %0h", $time, field, got, want);
    endtask

    // compare one result with the oldest prediction
    task automatic check_result();
        isect_t want;
        box_t   got;
        if (isect_due.size() == 0) begin
            flag_mismatch("result with no request outstanding", m_tuser, 0);
            return;
        end
        want = isect_due.pop_front();
        got  = m_tdata;
        if (m_tuser !== want.status)
            flag_mismatch("status", m_tuser, want.status);
        for (int k = 0; k < AXES; k++) begin
            if (got.lo[k] !== want.box.lo[k])
                flag_mismatch($sformatf("res_min axis %0d", k), got.lo[k], want.box.lo[k]);
            if (got.hi[k] !== want.box.hi[k])
                flag_mismatch($sformatf("res_max axis %0d", k), got.hi[k], want.box.hi[k]);
        end
    endtask

    // offer one request, idling first at the sender's rate
    task automatic offer_pair(input box_t a, input box_t b, input logic given,
                              input isect_t want);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        isect_due.push_back(given ? want : classify_boxes(a, b, tol_now));
    endtask

    // stop offering and wait for the pipeline to empty
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (isect_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] v);
        drain_and_settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        tol_now      = v;
    endtask

    // result side: random stalls, long hold-off on request, checking
    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
        if (aresetn && m_tvalid && m_tready)
            check_result();
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // stimulus
    initial begin
        pair_row_t dir_rows[$];
        box_t      a, b, unit, full;
        isect_t    none;
        none = '0;
        unit = mk_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
        full = mk_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);

        // reset-time tolerance is 1 for the whole table
        // invalid boxes
        dir_rows.push_back(row(mk_box(10, 0, 0, 5, 10, 10), mk_box(0, 0, 0, 1, 1, 1),
                               1'b1, ST_UNKNOWN, '0));
        dir_rows.push_back(row(mk_box(0, 0, 0, 10, 10, 10), mk_box(0, 0, 5, 1, 1, 4),
                               1'b1, ST_UNKNOWN, '0));
        dir_rows.push_back(row(mk_box(C_MAX, 0, 0, C_MIN, 0, 0),
                               mk_box(C_MAX, 0, 0, C_MIN, 0, 0), 1'b1, ST_UNKNOWN, '0));
        // disjoint
        dir_rows.push_back(row(mk_box(0, 0, 0, ONE, ONE, ONE),
                               mk_box(4*ONE, 0, 0, 5*ONE, ONE, ONE), 1'b1, ST_NOT, '0));
        dir_rows.push_back(row(mk_box(0, 0, 4*ONE, ONE, ONE, 5*ONE),
                               mk_box(0, 0, 0, ONE, ONE, ONE), 1'b1, ST_NOT, '0));
        dir_rows.push_back(row(mk_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN),
                               mk_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX),
                               1'b1, ST_NOT, '0));
        dir_rows.push_back(row(mk_box(0, 0, 0, 10, 10, 10), mk_box(12, 0, 0, 20, 10, 10),
                               1'b1, ST_NOT, '0));
        // identical boxes resolve to b inside a
        dir_rows.push_back(row(unit, unit, 1'b1, ST_B_IN_A, unit));
        dir_rows.push_back(row(full, full, 1'b1, ST_B_IN_A, full));
        // plain containment both ways
        dir_rows.push_back(row(mk_box(0, 0, 0, 8*ONE, 8*ONE, 8*ONE),
                               mk_box(ONE, 2*ONE, 3*ONE, 2*ONE, 3*ONE, 4*ONE), 1'b1,
                               ST_B_IN_A, mk_box(ONE, 2*ONE, 3*ONE, 2*ONE, 3*ONE, 4*ONE)));
        dir_rows.push_back(row(mk_box(ONE, 2*ONE, 3*ONE, 2*ONE, 3*ONE, 4*ONE),
                               mk_box(0, 0, 0, 8*ONE, 8*ONE, 8*ONE), 1'b1,
                               ST_A_IN_B, mk_box(ONE, 2*ONE, 3*ONE, 2*ONE, 3*ONE, 4*ONE)));
        // partial overlap
        dir_rows.push_back(row(mk_box(0, 0, 0, 4*ONE, 4*ONE, 4*ONE),
                               mk_box(2*ONE, ONE, -ONE, 6*ONE, 3*ONE, 5*ONE),
                               1'b0, ST_OK, '0));
        // touching within tolerance gives an inverted overlap box
        dir_rows.push_back(row(mk_box(0, 0, 0, 10, 10, 10), mk_box(11, 0, 0, 20, 10, 10),
                               1'b0, ST_OK, '0));
        // containment only thanks to the tolerance
        dir_rows.push_back(row(mk_box(0, 0, 0, 10, 10, 10), mk_box(-1, 0, 0, 11, 10, 10),
                               1'b0, ST_OK, '0));
        dir_rows.push_back(row(mk_box(0, 0, 0, 10, 10, 10), mk_box(1, -5, 0, 9, 15, 10),
                               1'b0, ST_OK, '0));
        // widened bounds at the top and bottom of the range
        dir_rows.push_back(row(mk_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX),
                               mk_box(C_MAX-1, C_MAX-1, C_MAX-1, C_MAX, C_MAX, C_MAX),
                               1'b0, ST_OK, '0));
        dir_rows.push_back(row(mk_box(C_MIN, C_MIN, C_MIN, C_MIN+1, C_MIN+1, C_MIN+1),
                               mk_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN),
                               1'b0, ST_OK, '0));
        dir_rows.push_back(row(mk_box(0, 0, 0, C_MAX, C_MAX, C_MAX),
                               mk_box(C_MIN, C_MIN, C_MIN, -2, C_MAX, C_MAX),
                               1'b0, ST_OK, '0));
        // degenerate point box and all-ones coordinates
        dir_rows.push_back(row(mk_box(5, 5, 5, 5, 5, 5), mk_box(0, 0, 0, 10, 10, 10),
                               1'b0, ST_OK, '0));
        dir_rows.push_back(row(mk_box(-1, -1, -1, -1, -1, -1), mk_box(0, 0, 0, 0, 0, 0),
                               1'b0, ST_OK, '0));

        // reset
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, then random pairs at the reset tolerance
        foreach (dir_rows[i])
            offer_pair(dir_rows[i].a, dir_rows[i].b, dir_rows[i].given, dir_rows[i].want);
        repeat (200) begin
            make_pair(a, b);
            offer_pair(a, b, 1'b0, none);
        end

        // random phases over several tolerance settings and stall patterns
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       write_tolerance('0);
                1:       write_tolerance('1);
                3:       write_tolerance(TOL_W'(16));
                default: write_tolerance(TOL_W'($urandom_range(2, 65534)));
            endcase
            if (p == 0) begin
                src_idle_pct = 38;
                snk_idle_pct = 78;
            end else if (p < 3) begin
                src_idle_pct = 78;
                snk_idle_pct = 38;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            // long result hold-off with the sender still pushing
            if (p == 3)
                hold_seq <= hold_seq + 1;
            repeat ((p == 0) ? 300 : (p == 4) ? 400 : 350) begin
                make_pair(a, b);
                offer_pair(a, b, 1'b0, none);
            end
        end

        drain_and_settle();
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
